/* rtl/hbc_pkg.sv */
package hbc_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIFF_W    = 33;
  localparam int unsigned RES_W     = 31;
  localparam int unsigned BCNT_W    = 7;
  localparam int unsigned BIN_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_STEPS = 33;
  localparam int unsigned DIV_CNT_W = 6;

  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT  = 2'd2;

  localparam logic [RES_W-1:0]  RESOLUTION_RST = 31'd1;
  localparam logic [BCNT_W-1:0] BIN_COUNT_RST  = 7'd64;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_ABS   = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_PICK  = 7'b0010000,
    ST_RD    = 7'b0100000,
    ST_UPD   = 7'b1000000
  } ctrl_state_e;

  typedef struct packed {
    logic clr;
    logic load;
    logic conv;
    logic step;
    logic pick;
    logic rd;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
  } sts_t;

endpackage

/* rtl/histogram_binning_counter.sv */
// Record item: after start is taken the item passes the magnitude step, the divider, bin
// selection, the memory read, the read-modify-write and the output register in order,
// then gives the result strobe; the next item may start then. The divider makes one
// quotient bit per cycle over a 33-bit difference.
// Read item: memory read, update and output register, then the result strobe.
// After reset all MAX_BINS+2 store entries are cleared one entry a cycle, with busy high.
// The result strobe lasts one cycle; the receiver cannot stall it.
module histogram_binning_counter #(
  parameter int unsigned MAX_BINS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              func_i,
  input  logic signed [hbc_pkg::DATA_W-1:0] sample_i,
  input  logic [hbc_pkg::BIN_W-1:0]         bin_index_i,
  output logic                              done_o,
  output logic [hbc_pkg::BIN_W-1:0]         bin_o,
  output logic [hbc_pkg::DATA_W-1:0]        count_o,
  input  logic                              cfg_we_i,
  input  logic [hbc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [hbc_pkg::DATA_W-1:0]        cfg_data_i
);
  import hbc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hbc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  hbc_datapath #(
    .MAX_BINS (MAX_BINS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .func_i      (func_i),
    .sample_i    (sample_i),
    .bin_index_i (bin_index_i),
    .bin_o       (bin_o),
    .count_o     (count_o),
    .done_o      (done_o)
  );

endmodule

/* rtl/hbc_ctrl.sv */
module hbc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          func_i,
  input  hbc_pkg::sts_t sts_i,
  output hbc_pkg::cmd_t cmd_o,
  output logic          busy
);
  import hbc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = (func_i == FUNC_READ) ? ST_RD : ST_ABS;
        end
      end
      ST_ABS: begin
        cmd_o.conv = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = ST_RD;
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  a_div_to_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && sts_i.div_last |=> (state_q == ST_PICK))
    else $error("divider did not hand over to bin selection");

  a_clear_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !cmd_o.load && !cmd_o.upd)
    else $error("item taken during the clearing pass");

  a_upd_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> $past(state_q) == ST_RD)
    else $error("update without a preceding memory read");

endmodule

/* rtl/hbc_datapath.sv */
module hbc_datapath #(
  parameter int unsigned MAX_BINS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  hbc_pkg::cmd_t                        cmd_i,
  output hbc_pkg::sts_t                        sts_o,
  input  logic                                 cfg_we_i,
  input  logic [hbc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [hbc_pkg::DATA_W-1:0]           cfg_data_i,
  input  logic                                 func_i,
  input  logic signed [hbc_pkg::DATA_W-1:0]    sample_i,
  input  logic [hbc_pkg::BIN_W-1:0]            bin_index_i,
  output logic [hbc_pkg::BIN_W-1:0]            bin_o,
  output logic [hbc_pkg::DATA_W-1:0]           count_o,
  output logic                                 done_o
);
  import hbc_pkg::*;

  localparam int unsigned NumSlots = MAX_BINS + 2;
  localparam int unsigned BinW     = $clog2(NumSlots);

  // Configuration registers.
  logic [DATA_W-1:0] min_q;
  logic [RES_W-1:0]  res_q;
  logic [BCNT_W-1:0] bcnt_q;

  // Item registers.
  logic              rec_q;
  logic              rng_q;
  logic [BIN_W-1:0]  idx_q;
  logic [BinW-1:0]   bin_q;
  logic [DIFF_W-1:0] diff_q;
  logic              neg_q;

  // Divider registers.
  logic [DIFF_W-1:0]    dvd_q;
  logic [RES_W-1:0]     dvs_q;
  logic [DATA_W-1:0]    rem_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;

  logic [BinW-1:0]   clr_cnt_q;
  logic [DATA_W-1:0] mem_q [NumSlots];
  logic [DATA_W-1:0] rdata_q;
  logic              out_vld_q;

  logic [BinW-1:0]   nb;
  logic [DATA_W-1:0] trial;
  logic              ge;
  logic [BinW-1:0]   pick_bin;
  logic [DATA_W-1:0] incr;
  logic              idx_rng;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= '0;
      res_q  <= RESOLUTION_RST;
      bcnt_q <= BIN_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_VALUE:  min_q  <= cfg_data_i;
        REG_RESOLUTION: res_q  <= cfg_data_i[RES_W-1:0];
        REG_BIN_COUNT:  bcnt_q <= cfg_data_i[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Regular bins in use, limited to MAX_BINS.
  assign nb = (32'(bcnt_q) > MAX_BINS) ? BinW'(MAX_BINS) : BinW'(bcnt_q);

  assign idx_rng = (32'(bin_index_i) < NumSlots);

  // One restoring step: the remainder stays below the divisor, so its top bit is free.
  assign trial = {rem_q[DATA_W-2:0], dvd_q[DIFF_W-1]};
  assign ge    = (trial >= {1'b0, dvs_q});

  // A negative difference smaller than one bin truncates to zero and lands in bin 1.
  always_comb begin
    if (neg_q && (dvd_q != '0)) begin
      pick_bin = '0;
    end else if (dvd_q < DIFF_W'(nb)) begin
      pick_bin = BinW'(dvd_q) + BinW'(1);
    end else begin
      pick_bin = nb + BinW'(1);
    end
  end

  assign incr = rdata_q + DATA_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rec_q  <= (func_i == FUNC_RECORD);
      rng_q  <= (func_i == FUNC_RECORD) || idx_rng;
      idx_q  <= bin_index_i;
      bin_q  <= idx_rng ? BinW'(bin_index_i) : '0;
      diff_q <= {sample_i[DATA_W-1], sample_i} - {min_q[DATA_W-1], min_q};
    end
    if (cmd_i.conv) begin
      neg_q <= diff_q[DIFF_W-1];
      dvd_q <= diff_q[DIFF_W-1] ? (DIFF_W'(0) - diff_q) : diff_q;
      dvs_q <= (res_q == '0) ? RES_W'(1) : res_q;
      rem_q <= '0;
    end
    if (cmd_i.step) begin
      rem_q <= ge ? (trial - {1'b0, dvs_q}) : trial;
      dvd_q <= {dvd_q[DIFF_W-2:0], ge};
    end
    if (cmd_i.pick) begin
      bin_q <= pick_bin;
    end
    if (cmd_i.upd) begin
      bin_o   <= rec_q ? BIN_W'(bin_q) : idx_q;
      count_o <= rec_q ? incr : (rng_q ? rdata_q : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
      clr_cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.conv) begin
        div_cnt_q <= '0;
      end else if (cmd_i.step) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + BinW'(1);
      end
      out_vld_q <= cmd_i.upd;
    end
  end

  // Bin store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (cmd_i.upd && rec_q) begin
      mem_q[bin_q] <= incr;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[bin_q];
    end
  end

  assign sts_o.clr_last = (clr_cnt_q == BinW'(NumSlots - 1));
  assign sts_o.div_last = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign done_o         = out_vld_q;

  a_div_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (32'(div_cnt_q) < DIV_STEPS))
    else $error("divider ran past its last quotient bit");

  a_far_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !rec_q && !rng_q |-> (count_o == '0))
    else $error("read beyond the store returned a nonzero count");

  a_rec_bin_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && rec_q |-> (32'(bin_q) <= 32'(nb) + 32'd1))
    else $error("recorded item landed beyond the overflow bin");

endmodule
